>>> rtl/core/iqs_pkg.sv
`timescale 1ns / 1ps

package iqs_pkg;

  localparam int SLOTS       = 32;
  localparam int PHYS_REGS   = 256;
  localparam int ISSUE_PORTS = 4;
  localparam int SOURCES     = 3;

  localparam int IN_SRCS = 3;
  localparam int REG_W   = 8;
  localparam int TAG_W   = 8;
  localparam int PORT_W  = 2;
  localparam int MASK_W  = 4;
  localparam int LIMIT_W = 6;
  localparam int STAT_W  = 3;

  localparam int SLOT_IDX_W  = $clog2(SLOTS);
  localparam int COUNT_W     = $clog2(SLOTS + 1);
  localparam int REG_AW      = $clog2(PHYS_REGS);
  localparam int ISSUE_WIDTH = (ISSUE_PORTS < 4) ? ISSUE_PORTS : 4;
  localparam int ISSUE_CNT_W = $clog2(ISSUE_WIDTH + 1);

  typedef enum logic [1:0] {
    MODE_DISPATCH  = 2'd0,
    MODE_WAKEUP    = 2'd1,
    MODE_SET_READY = 2'd2,
    MODE_ISSUE     = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DISPATCHED = 3'd0,
    ST_FULL       = 3'd1,
    ST_ISSUED     = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_BACKEND    = 3'd4,
    ST_UPDATED    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_DISP,
    S_RESP,
    S_SCAN,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]               tag;
    logic [PORT_W-1:0]              port;
    logic [IN_SRCS-1:0][REG_W-1:0]  srcs;
    logic [IN_SRCS-1:0]             waiting;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_NEXT,
    CELL_TAKE_HEAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic              wake;
    logic [REG_W-1:0]  wake_reg;
  } cell_ctrl_t;

endpackage

>>> rtl/core/iqs_ram.sv
`timescale 1ns / 1ps

module iqs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/iqs_cell.sv
`timescale 1ns / 1ps

module iqs_cell (
  input  logic                clk,
  input  iqs_pkg::cell_ctrl_t ctrl,
  input  iqs_pkg::entry_t     load_data,
  input  iqs_pkg::entry_t     next_data,
  input  iqs_pkg::entry_t     head_data,
  output iqs_pkg::entry_t     data
);

  iqs_pkg::entry_t woken;

  always_comb begin
    woken = data;
    for (int i = 0; i < iqs_pkg::IN_SRCS; i++) begin
      if (ctrl.wake && data.srcs[i] == ctrl.wake_reg) begin
        woken.waiting[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      iqs_pkg::CELL_LOAD:      data <= load_data;
      iqs_pkg::CELL_TAKE_NEXT: data <= next_data;
      iqs_pkg::CELL_TAKE_HEAD: data <= head_data;
      default:                 data <= woken;
    endcase
  end

endmodule

>>> rtl/core/issue_queue_scoreboard.sv
// Issue queue with a register scoreboard.
// Input transactions use in_valid / in_stall and carry a mode: dispatch,
// writeback with wakeup, set ready, or issue cycle. Result transactions use
// out_valid / out_stall, and the final result of each input carries last.
// The station is a row of entry cells kept in age order, oldest in cell 0.
// A dispatch reads its three sources from the scoreboard RAM one per cycle;
// writeback, set ready and refused dispatches go straight to a response. An
// issue cycle rotates the station through cell 0 one entry per cycle unless
// a stalled result holds it, with one result per issued entry, or a backend
// result if none issues. One input is handled at a time, the next taken in
// idle even while the last result waits in the output register. A stalled
// result holds and the block waits to emit. The user must write the station
// limit through cfg_write / cfg_data only while idle; the block does not
// enforce it. Reset empties the station, marks every register ready through
// per-register valid bits, and sets the limit to 32.
`timescale 1ns / 1ps

module issue_queue_scoreboard (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [iqs_pkg::LIMIT_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [iqs_pkg::TAG_W-1:0]     uop_tag,
  input  logic                          src_a_valid,
  input  logic [iqs_pkg::REG_W-1:0]     src_a_reg,
  input  logic                          src_b_valid,
  input  logic [iqs_pkg::REG_W-1:0]     src_b_reg,
  input  logic                          src_c_valid,
  input  logic [iqs_pkg::REG_W-1:0]     src_c_reg,
  input  logic                          dest_valid,
  input  logic [iqs_pkg::REG_W-1:0]     dest_reg,
  input  logic [iqs_pkg::PORT_W-1:0]    exec_port,
  input  logic [iqs_pkg::MASK_W-1:0]    port_free_mask,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [iqs_pkg::STAT_W-1:0]    status,
  output logic [iqs_pkg::TAG_W-1:0]     issued_tag,
  output logic [iqs_pkg::PORT_W-1:0]    issued_port,
  output logic                          out_of_order,
  output logic                          last
);

  iqs_pkg::state_t state, state_next;

  logic [iqs_pkg::LIMIT_W-1:0]     station_limit;
  logic [iqs_pkg::COUNT_W-1:0]     count;
  logic [iqs_pkg::SLOT_IDX_W-1:0]  step_cnt;
  logic [iqs_pkg::SLOT_IDX_W-1:0]  scan_last;
  logic [iqs_pkg::ISSUE_CNT_W-1:0] issued_cnt;
  logic [iqs_pkg::MASK_W-1:0]      free_mask;
  logic                            kept_any;
  logic                            pend_valid;
  logic [iqs_pkg::PHYS_REGS-1:0]   written;
  logic                            rd_written;

  iqs_pkg::mode_t                            mode_q;
  logic [iqs_pkg::TAG_W-1:0]                 tag_q;
  logic [iqs_pkg::IN_SRCS-1:0]               src_valid_q;
  logic [iqs_pkg::IN_SRCS-1:0][iqs_pkg::REG_W-1:0] src_reg_q;
  logic                                      dest_valid_q;
  logic [iqs_pkg::REG_W-1:0]                 dest_q;
  logic [iqs_pkg::PORT_W-1:0]                port_q;
  iqs_pkg::status_t                          resp_status;
  logic [1:0]                                wait_ab;
  logic [iqs_pkg::TAG_W-1:0]                 pend_tag;
  logic [iqs_pkg::PORT_W-1:0]                pend_port;
  logic                                      pend_ooo;

  iqs_pkg::entry_t     cells [iqs_pkg::SLOTS];
  iqs_pkg::cell_ctrl_t ctrl  [iqs_pkg::SLOTS];
  iqs_pkg::entry_t     load_data;
  iqs_pkg::entry_t     head;

  logic                         in_fire;
  logic                         out_room;
  logic                         full;
  logic                         head_ok;
  logic                         step;
  logic                         emit;
  iqs_pkg::status_t             emit_status;
  logic [iqs_pkg::TAG_W-1:0]    emit_tag;
  logic [iqs_pkg::PORT_W-1:0]   emit_port;
  logic                         emit_ooo;
  logic                         emit_last;
  logic                         ram_we;
  logic                         ram_wdata;
  logic [iqs_pkg::REG_AW-1:0]   ram_waddr;
  logic [iqs_pkg::REG_AW-1:0]   ram_raddr;
  logic [iqs_pkg::REG_W-1:0]    rd_reg;
  logic                         ram_q;
  logic                         rd_ready;
  logic                         wait_c;

  assign in_stall = (state != iqs_pkg::S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_room = !out_valid || !out_stall;
  assign head     = cells[0];

  assign full = int'(count) >= ((int'(station_limit) < iqs_pkg::SLOTS) ?
                                int'(station_limit) : iqs_pkg::SLOTS);

  assign head_ok = (int'(issued_cnt) < iqs_pkg::ISSUE_WIDTH) && (head.waiting == '0) &&
                   (int'(head.port) < iqs_pkg::ISSUE_PORTS) && free_mask[head.port];

  assign ram_waddr = iqs_pkg::REG_AW'(dest_q);
  assign ram_raddr = iqs_pkg::REG_AW'(rd_reg);

  always_comb begin
    case (state)
      iqs_pkg::S_RD_A: rd_reg = src_reg_q[0];
      iqs_pkg::S_RD_B: rd_reg = src_reg_q[1];
      default:         rd_reg = src_reg_q[2];
    endcase
  end

  always_comb begin
    case (state)
      iqs_pkg::S_RD_B: rd_ready = !(int'(src_reg_q[0]) < iqs_pkg::PHYS_REGS) ||
                                  !rd_written || ram_q;
      iqs_pkg::S_RD_C: rd_ready = !(int'(src_reg_q[1]) < iqs_pkg::PHYS_REGS) ||
                                  !rd_written || ram_q;
      default:         rd_ready = !(int'(src_reg_q[2]) < iqs_pkg::PHYS_REGS) ||
                                  !rd_written || ram_q;
    endcase
  end

  assign wait_c = src_valid_q[2] && !rd_ready && (2 < iqs_pkg::SOURCES);

  always_comb begin
    load_data.tag     = tag_q;
    load_data.port    = port_q;
    load_data.srcs    = src_reg_q;
    load_data.waiting = {wait_c, wait_ab};
  end

  iqs_ram #(
    .WIDTH(1),
    .DEPTH(iqs_pkg::PHYS_REGS)
  ) u_ready_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  for (genvar g = 0; g < iqs_pkg::SLOTS; g++) begin : g_cell
    iqs_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[g]),
      .load_data (load_data),
      .next_data (cells[(g + 1) % iqs_pkg::SLOTS]),
      .head_data (head),
      .data      (cells[g])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      iqs_pkg::S_IDLE: begin
        if (in_fire) begin
          case (iqs_pkg::mode_t'(mode))
            iqs_pkg::MODE_DISPATCH: state_next = full ? iqs_pkg::S_RESP : iqs_pkg::S_RD_A;
            iqs_pkg::MODE_ISSUE:    state_next = (count == '0) ? iqs_pkg::S_RESP :
                                                                 iqs_pkg::S_SCAN;
            default:                state_next = iqs_pkg::S_RESP;
          endcase
        end
      end
      iqs_pkg::S_RD_A: state_next = iqs_pkg::S_RD_B;
      iqs_pkg::S_RD_B: state_next = iqs_pkg::S_RD_C;
      iqs_pkg::S_RD_C: state_next = iqs_pkg::S_DISP;
      iqs_pkg::S_DISP,
      iqs_pkg::S_RESP,
      iqs_pkg::S_FLUSH: begin
        if (out_room) begin
          state_next = iqs_pkg::S_IDLE;
        end
      end
      iqs_pkg::S_SCAN: begin
        if (step && step_cnt == scan_last) begin
          state_next = iqs_pkg::S_FLUSH;
        end
      end
      default: state_next = iqs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    emit        = 1'b0;
    emit_status = iqs_pkg::ST_UPDATED;
    emit_tag    = '0;
    emit_port   = '0;
    emit_ooo    = 1'b0;
    emit_last   = 1'b1;
    ram_we      = 1'b0;
    ram_wdata   = 1'b1;
    step        = 1'b0;
    for (int i = 0; i < iqs_pkg::SLOTS; i++) begin
      ctrl[i].op       = iqs_pkg::CELL_HOLD;
      ctrl[i].wake     = 1'b0;
      ctrl[i].wake_reg = dest_q;
    end
    case (state)
      iqs_pkg::S_DISP: begin
        if (out_room) begin
          emit        = 1'b1;
          emit_status = iqs_pkg::ST_DISPATCHED;
          ram_we      = dest_valid_q && (int'(dest_q) < iqs_pkg::PHYS_REGS);
          ram_wdata   = 1'b0;
          for (int i = 0; i < iqs_pkg::SLOTS; i++) begin
            if (i == int'(count)) begin
              ctrl[i].op = iqs_pkg::CELL_LOAD;
            end
          end
        end
      end
      iqs_pkg::S_RESP: begin
        if (out_room) begin
          emit        = 1'b1;
          emit_status = resp_status;
          if (mode_q == iqs_pkg::MODE_WAKEUP || mode_q == iqs_pkg::MODE_SET_READY) begin
            ram_we = int'(dest_q) < iqs_pkg::PHYS_REGS;
          end
          for (int i = 0; i < iqs_pkg::SLOTS; i++) begin
            ctrl[i].wake = (mode_q == iqs_pkg::MODE_WAKEUP);
          end
        end
      end
      iqs_pkg::S_SCAN: begin
        step = !(head_ok && pend_valid && !out_room);
        if (step) begin
          if (head_ok && pend_valid) begin
            emit        = 1'b1;
            emit_status = iqs_pkg::ST_ISSUED;
            emit_tag    = pend_tag;
            emit_port   = pend_port;
            emit_ooo    = pend_ooo;
            emit_last   = 1'b0;
          end
          for (int i = 0; i < iqs_pkg::SLOTS; i++) begin
            if (i + 1 < int'(count)) begin
              ctrl[i].op = iqs_pkg::CELL_TAKE_NEXT;
            end else if (i + 1 == int'(count) && !head_ok) begin
              ctrl[i].op = iqs_pkg::CELL_TAKE_HEAD;
            end
          end
        end
      end
      iqs_pkg::S_FLUSH: begin
        if (out_room) begin
          emit = 1'b1;
          if (pend_valid) begin
            emit_status = iqs_pkg::ST_ISSUED;
            emit_tag    = pend_tag;
            emit_port   = pend_port;
            emit_ooo    = pend_ooo;
          end else begin
            emit_status = iqs_pkg::ST_BACKEND;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= iqs_pkg::S_IDLE;
      station_limit <= iqs_pkg::LIMIT_W'(32);
      count         <= '0;
      written       <= '0;
      out_valid     <= 1'b0;
      pend_valid    <= 1'b0;
      issued_cnt    <= '0;
      kept_any      <= 1'b0;
      step_cnt      <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        station_limit <= cfg_data;
      end
      if (ram_we) begin
        written[ram_waddr] <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        pend_valid <= 1'b0;
        issued_cnt <= '0;
        kept_any   <= 1'b0;
        step_cnt   <= '0;
      end
      if (state == iqs_pkg::S_DISP && out_room) begin
        count <= count + iqs_pkg::COUNT_W'(1);
      end
      if (step) begin
        step_cnt <= step_cnt + iqs_pkg::SLOT_IDX_W'(1);
        if (head_ok) begin
          pend_valid <= 1'b1;
          count      <= count - iqs_pkg::COUNT_W'(1);
          issued_cnt <= issued_cnt + iqs_pkg::ISSUE_CNT_W'(1);
        end else begin
          kept_any <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_written <= written[ram_raddr];
    if (in_fire) begin
      mode_q       <= iqs_pkg::mode_t'(mode);
      tag_q        <= uop_tag;
      src_valid_q  <= {src_c_valid, src_b_valid, src_a_valid};
      src_reg_q    <= {src_c_reg, src_b_reg, src_a_reg};
      dest_valid_q <= dest_valid;
      dest_q       <= dest_reg;
      port_q       <= exec_port;
      free_mask    <= port_free_mask;
      scan_last    <= iqs_pkg::SLOT_IDX_W'(count - iqs_pkg::COUNT_W'(1));
      case (iqs_pkg::mode_t'(mode))
        iqs_pkg::MODE_DISPATCH: resp_status <= iqs_pkg::ST_FULL;
        iqs_pkg::MODE_ISSUE:    resp_status <= iqs_pkg::ST_EMPTY;
        default:                resp_status <= iqs_pkg::ST_UPDATED;
      endcase
    end
    if (state == iqs_pkg::S_RD_B) begin
      wait_ab[0] <= src_valid_q[0] && !rd_ready && (0 < iqs_pkg::SOURCES);
    end
    if (state == iqs_pkg::S_RD_C) begin
      wait_ab[1] <= src_valid_q[1] && !rd_ready && (1 < iqs_pkg::SOURCES);
    end
    if (step && head_ok) begin
      pend_tag  <= head.tag;
      pend_port <= head.port;
      pend_ooo  <= kept_any;
      free_mask <= free_mask & ~(iqs_pkg::MASK_W'(1) << head.port);
    end
    if (emit) begin
      status       <= emit_status;
      issued_tag   <= emit_tag;
      issued_port  <= emit_port;
      out_of_order <= emit_ooo;
      last         <= emit_last;
    end
  end

endmodule

>>> rtl/core/iqs_checker.sv
`timescale 1ns / 1ps

module iqs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [iqs_pkg::STAT_W-1:0]   status,
  input logic [iqs_pkg::TAG_W-1:0]    issued_tag,
  input logic [iqs_pkg::PORT_W-1:0]   issued_port,
  input logic                         out_of_order,
  input logic                         last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(issued_tag))
    else $error("Stalled result transaction changed.");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= iqs_pkg::ST_UPDATED)
    else $error("Result status code out of range.");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != iqs_pkg::ST_ISSUED |->
      issued_tag == '0 && issued_port == '0 && !out_of_order)
    else $error("Non-issue result carries issue fields.");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != iqs_pkg::ST_ISSUED |-> last)
    else $error("Single result transaction without last.");

endmodule

bind issue_queue_scoreboard iqs_checker u_iqs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .issued_tag   (issued_tag),
  .issued_port  (issued_port),
  .out_of_order (out_of_order),
  .last         (last)
);
